@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the port checker file
// Immediate-consequent and next-cycle implication properties.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre holds -> post holds in the same cycle
`define CAC_ASSERT_IMPL(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("cac checker: implication violated");

// pre holds -> post holds in the next cycle
`define CAC_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("cac checker: next-cycle implication violated");

`endif

@@ hw/rtl/cac_pkg.sv @@
// ----------------------------------------------------------------------------
// cac_pkg
// Types and codes shared by the card access controller modules.
// ----------------------------------------------------------------------------
package cac_pkg;

	localparam int CARD_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ADD_SUP       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_SUP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_ALL_SUP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS    = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0] RST_ADD_SUP       = 16'd24151;
	localparam logic [CFG_W-1:0] RST_ERASE_SUP     = 16'd35907;
	localparam logic [CFG_W-1:0] RST_ERASE_ALL_SUP = 16'd41255;
	localparam logic [CFG_W-1:0] RST_OPEN_TICKS    = 16'd2000;
	localparam logic [CFG_W-1:0] RST_WAIT_TICKS    = 16'd3000;

	// event command codes
	localparam logic CMD_CARD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// empty table slot
	localparam logic [CARD_W-1:0] EMPTY_SLOT = 16'h0000;

	// controller modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_OPEN  = 2'd1;
	localparam logic [1:0] MODE_ERASE = 2'd2;
	localparam logic [1:0] MODE_ADD   = 2'd3;

	// result status codes
	localparam logic [3:0] STAT_NONE       = 4'd0;
	localparam logic [3:0] STAT_OPENED     = 4'd1;
	localparam logic [3:0] STAT_ADDED      = 4'd2;
	localparam logic [3:0] STAT_PRESENT    = 4'd3;
	localparam logic [3:0] STAT_FULL       = 4'd4;
	localparam logic [3:0] STAT_ERASED     = 4'd5;
	localparam logic [3:0] STAT_NOT_FOUND  = 4'd6;
	localparam logic [3:0] STAT_ALL_ERASED = 4'd7;
	localparam logic [3:0] STAT_REJECTED   = 4'd8;
	localparam logic [3:0] STAT_TIMEOUT    = 4'd9;
	localparam logic [3:0] STAT_CLOSED     = 4'd10;

	// card class decided in the front end
	typedef enum logic [1:0] {
		KIND_SUP_ADD       = 2'd0,
		KIND_SUP_ERASE     = 2'd1,
		KIND_SUP_ERASE_ALL = 2'd2,
		KIND_CARD          = 2'd3
	} kind_t;

	typedef struct packed {
		logic              command;
		logic [CARD_W-1:0] card_number;
		kind_t             kind;
	} item_t;

	typedef struct packed {
		logic [CFG_W-1:0] add_sup_id;
		logic [CFG_W-1:0] erase_sup_id;
		logic [CFG_W-1:0] erase_all_sup_id;
		logic [CFG_W-1:0] open_ticks;
		logic [CFG_W-1:0] wait_ticks;
	} cfg_t;

endpackage

@@ hw/rtl/cac_ifs.sv @@
// ----------------------------------------------------------------------------
// cac channel interfaces
// Valid/ready channels for events into and results out of the controller.
// ----------------------------------------------------------------------------

// event channel: card read or timer tick
interface cac_event_if import cac_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [CARD_W-1:0] card_number;

	modport source(output valid, command, card_number, input ready);
	modport sink(input valid, command, card_number, output ready);
endinterface

// result channel: one result per event
interface cac_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       door_open;
	logic       busy_blink;
	logic       ok_flash;
	logic [3:0] status;

	modport source(output valid, mode, door_open, busy_blink, ok_flash, status, input ready);
	modport sink(input valid, mode, door_open, busy_blink, ok_flash, status, output ready);
endinterface

@@ hw/rtl/cac_front.sv @@
// ----------------------------------------------------------------------------
// cac_front
// Accepts events and classifies card numbers against the supervisor IDs.
// ----------------------------------------------------------------------------
module cac_front import cac_pkg::*; (
	cac_event_if.sink event_ch,
	input  cfg_t      cfg,
	input  logic      clearing,
	input  logic      q_full,
	output logic      push,
	output item_t     push_item
);

	kind_t kind;

	// supervisor match, first ID in register order wins
	always_comb begin
		if (event_ch.card_number == cfg.add_sup_id) begin
			kind = KIND_SUP_ADD;
		end else if (event_ch.card_number == cfg.erase_sup_id) begin
			kind = KIND_SUP_ERASE;
		end else if (event_ch.card_number == cfg.erase_all_sup_id) begin
			kind = KIND_SUP_ERASE_ALL;
		end else begin
			kind = KIND_CARD;
		end
	end

	// no transaction while the table is being swept
	assign event_ch.ready = !q_full && !clearing;
	assign push = event_ch.valid && event_ch.ready;

	assign push_item.command     = event_ch.command;
	assign push_item.card_number = event_ch.card_number;
	assign push_item.kind        = kind;

endmodule

@@ hw/rtl/cac_queue.sv @@
// ----------------------------------------------------------------------------
// cac_queue
// Short FIFO of classified events between the front and back ends.
// ----------------------------------------------------------------------------
module cac_queue import cac_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  not_empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);

	item_t            slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/cac_back.sv @@
// ----------------------------------------------------------------------------
// cac_back
// Executes events: card table scan, mode/countdown update, table writes,
// clearing sweep and the result register.
// ----------------------------------------------------------------------------
module cac_back import cac_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic q_valid,
	input  item_t q_item,
	output logic pop,
	output logic clearing,
	cac_result_if.source result_ch
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_EXEC  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  addr_q;
	item_t             cur_q;
	logic              found_hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              found_empty_q;
	logic [IDX_W-1:0]  empty_idx_q;
	logic [CARD_W-1:0] rd_data_s1;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [1:0]        mode_q;
	logic [CFG_W-1:0]  countdown_q;

	logic              out_valid_q;
	logic [1:0]        out_mode_q;
	logic              out_ok_q;
	logic [3:0]        out_status_q;

	logic [CARD_W-1:0] table_mem [TABLE_ENTRIES];

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [CARD_W-1:0] wr_data;

	logic              out_free;
	logic              fire_exec;
	logic              reg_card;
	logic              new_card;
	logic [1:0]        nxt_mode;
	logic [CFG_W-1:0]  nxt_cd;
	logic [3:0]        res_status;
	logic              res_ok;
	logic              tbl_we;
	logic [IDX_W-1:0]  tbl_addr;
	logic [CARD_W-1:0] tbl_data;
	logic              do_clear;

	assign out_free  = !out_valid_q || result_ch.ready;
	assign fire_exec = (state_q == S_EXEC) && out_free;
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign clearing  = (state_q == S_CLEAR);

	// table write port: sweep or single-entry update
	assign wr_en   = (state_q == S_CLEAR) || (fire_exec && tbl_we);
	assign wr_addr = (state_q == S_CLEAR) ? addr_q : tbl_addr;
	assign wr_data = (state_q == S_CLEAR) ? EMPTY_SLOT : tbl_data;

	// card table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= table_mem[addr_q];
		rd_idx_s1  <= addr_q;
	end

	assign reg_card = (cur_q.kind == KIND_CARD) && found_hit_q;
	assign new_card = (cur_q.kind == KIND_CARD) && !found_hit_q;

	// event execution
	always_comb begin
		nxt_mode   = mode_q;
		nxt_cd     = countdown_q;
		res_status = STAT_NONE;
		res_ok     = 1'b0;
		tbl_we     = 1'b0;
		tbl_addr   = hit_idx_q;
		tbl_data   = EMPTY_SLOT;
		do_clear   = 1'b0;
		if (cur_q.command == CMD_TICK) begin
			if (mode_q != MODE_IDLE) begin
				if (countdown_q <= 16'd1) begin
					nxt_cd     = '0;
					res_status = (mode_q == MODE_OPEN) ? STAT_CLOSED : STAT_TIMEOUT;
					nxt_mode   = MODE_IDLE;
				end else begin
					nxt_cd = countdown_q - 1'b1;
				end
			end
		end else begin
			case (mode_q)
				MODE_IDLE: begin
					if (reg_card) begin
						nxt_mode   = MODE_OPEN;
						nxt_cd     = cfg.open_ticks;
						res_status = STAT_OPENED;
					end else if (cur_q.kind == KIND_SUP_ERASE_ALL) begin
						do_clear   = 1'b1;
						res_status = STAT_ALL_ERASED;
						res_ok     = 1'b1;
					end else if (cur_q.kind == KIND_SUP_ERASE) begin
						nxt_mode = MODE_ERASE;
						nxt_cd   = cfg.wait_ticks;
					end else if (cur_q.kind == KIND_SUP_ADD) begin
						nxt_mode = MODE_ADD;
						nxt_cd   = cfg.wait_ticks;
					end else begin
						res_status = STAT_REJECTED;
					end
				end
				MODE_OPEN: begin
					nxt_mode   = MODE_IDLE;
					res_status = STAT_CLOSED;
				end
				MODE_ERASE: begin
					nxt_mode = MODE_IDLE;
					if (reg_card) begin
						tbl_we     = 1'b1;
						res_status = STAT_ERASED;
						res_ok     = 1'b1;
					end else begin
						res_status = STAT_NOT_FOUND;
					end
				end
				default: begin
					// add mode
					nxt_mode = MODE_IDLE;
					if (new_card) begin
						if (cur_q.card_number == EMPTY_SLOT) begin
							res_status = STAT_REJECTED;
						end else begin
							res_ok = 1'b1;
							if (found_empty_q) begin
								tbl_we     = 1'b1;
								tbl_addr   = empty_idx_q;
								tbl_data   = cur_q.card_number;
								res_status = STAT_ADDED;
							end else begin
								res_status = STAT_FULL;
							end
						end
					end else if (reg_card) begin
						res_status = STAT_PRESENT;
					end else begin
						res_status = STAT_REJECTED;
					end
				end
			endcase
		end
	end

	// sequencer, scan results and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			addr_q        <= '0;
			cur_q         <= '0;
			found_hit_q   <= 1'b0;
			hit_idx_q     <= '0;
			found_empty_q <= 1'b0;
			empty_idx_q   <= '0;
			rd_vld_s1     <= 1'b0;
			mode_q        <= MODE_IDLE;
			countdown_q   <= '0;
			out_valid_q   <= 1'b0;
			out_mode_q    <= MODE_IDLE;
			out_ok_q      <= 1'b0;
			out_status_q  <= STAT_NONE;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);

			// first match and first empty slot, in table order
			if (rd_vld_s1) begin
				if (!found_hit_q && (cur_q.card_number != EMPTY_SLOT)
						&& (rd_data_s1 == cur_q.card_number)) begin
					found_hit_q <= 1'b1;
					hit_idx_q   <= rd_idx_s1;
				end
				if (!found_empty_q && (rd_data_s1 == EMPTY_SLOT)) begin
					found_empty_q <= 1'b1;
					empty_idx_q   <= rd_idx_s1;
				end
			end

			case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						cur_q         <= q_item;
						addr_q        <= '0;
						found_hit_q   <= 1'b0;
						found_empty_q <= 1'b0;
						state_q       <= (q_item.command == CMD_TICK) ? S_EXEC : S_SCAN;
					end
				end
				S_SCAN: begin
					if (addr_q == LAST_IDX) begin
						addr_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						mode_q      <= nxt_mode;
						countdown_q <= nxt_cd;
						addr_q      <= '0;
						state_q     <= do_clear ? S_CLEAR : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// result register
			if (fire_exec) begin
				out_valid_q  <= 1'b1;
				out_mode_q   <= nxt_mode;
				out_ok_q     <= res_ok;
				out_status_q <= res_status;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.mode       = out_mode_q;
	assign result_ch.door_open  = (out_mode_q == MODE_OPEN);
	assign result_ch.busy_blink = (out_mode_q == MODE_ERASE) || (out_mode_q == MODE_ADD);
	assign result_ch.ok_flash   = out_ok_q;
	assign result_ch.status     = out_status_q;

endmodule

@@ hw/rtl/card_access_controller.sv @@
// ----------------------------------------------------------------------------
// card_access_controller
// Door access controller with a card whitelist table and supervisor cards.
// ----------------------------------------------------------------------------
// Each event (card read or timer tick) yields exactly one result transaction.
// A tick skips the table; a card read scans the card table linearly through
// its single read port. After reset, and after an erase-all card taken in
// idle mode, the table is swept to empty one entry per cycle; the event
// channel is not ready during the sweep, configuration writes are taken at
// any time. A two-entry queue between classification and execution lets
// events be taken while a result waits on the output.
module card_access_controller import cac_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cac_event_if.sink            event_ch,
	cac_result_if.source         result_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t  cfg_q;
	logic  clearing;
	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	item_t pop_item;
	logic  q_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.add_sup_id       <= RST_ADD_SUP;
			cfg_q.erase_sup_id     <= RST_ERASE_SUP;
			cfg_q.erase_all_sup_id <= RST_ERASE_ALL_SUP;
			cfg_q.open_ticks       <= RST_OPEN_TICKS;
			cfg_q.wait_ticks       <= RST_WAIT_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADD_SUP:       cfg_q.add_sup_id       <= cfg_data;
				REG_ERASE_SUP:     cfg_q.erase_sup_id     <= cfg_data;
				REG_ERASE_ALL_SUP: cfg_q.erase_all_sup_id <= cfg_data;
				REG_OPEN_TICKS:    cfg_q.open_ticks       <= cfg_data;
				REG_WAIT_TICKS:    cfg_q.wait_ticks       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cac_front u_front (
		.event_ch  (event_ch),
		.cfg       (cfg_q),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	cac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (q_valid)
	);

	cac_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.pop       (pop),
		.clearing  (clearing),
		.result_ch (result_ch)
	);

endmodule

@@ hw/rtl/cac_checker.sv @@
// ----------------------------------------------------------------------------
// cac_port_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cac_port_checker import cac_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] mode,
	input logic       door_open,
	input logic       busy_blink,
	input logic       ok_flash,
	input logic [3:0] status
);

	logic stalled;
	logic busy_mode;
	logic ok_kind;

	assign stalled   = out_valid && !out_ready;
	assign busy_mode = (mode == MODE_ERASE) || (mode == MODE_ADD);
	assign ok_kind   = (status == STAT_ADDED) || (status == STAT_FULL)
		|| (status == STAT_ERASED) || (status == STAT_ALL_ERASED);

	// a stalled result transaction stays valid and keeps its mode and status
	`CAC_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable({mode, status}))

	// indicator flags follow the mode
	`CAC_ASSERT_IMPL(a_door_mode, clk, arst_n, out_valid, door_open == (mode == MODE_OPEN))
	`CAC_ASSERT_IMPL(a_blink_mode, clk, arst_n, out_valid, busy_blink == busy_mode)

	// ok flag only with an added, full, erased or all-erased status
	`CAC_ASSERT_IMPL(a_ok_status, clk, arst_n, out_valid && ok_flash, ok_kind)

	// an opened door reports door-open mode and no ok flag
	`CAC_ASSERT_IMPL(a_opened_mode, clk, arst_n, out_valid && status == STAT_OPENED, mode == MODE_OPEN && !ok_flash)

endmodule

bind card_access_controller cac_port_checker u_cac_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.mode       (result_ch.mode),
	.door_open  (result_ch.door_open),
	.busy_blink (result_ch.busy_blink),
	.ok_flash   (result_ch.ok_flash),
	.status     (result_ch.status)
);

@@ tb/cac_checker.sv @@
// ----------------------------------------------------------------------------
// cac_checker
// Watches the event, result and register ports of the card access
// controller. It keeps its own copy of the card table, mode and countdown,
// predicts one result per accepted event and compares each accepted result,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module cac_checker import cac_pkg::*; #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	cac_event_if                 ev,
	cac_result_if                res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 run_done,
	output int                   mismatches
);

	typedef enum logic [2:0] {
		CLS_SUP_ADD,
		CLS_SUP_ERASE,
		CLS_SUP_ERASE_ALL,
		CLS_KNOWN,
		CLS_UNKNOWN
	} card_class_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       door_open;
		logic       busy_blink;
		logic       ok_flash;
		logic [3:0] status;
	} outcome_t;

	logic [CARD_W-1:0] cards [TABLE_ENTRIES];
	logic [1:0]        cur_mode;
	logic [CFG_W-1:0]  ticks_left;
	cfg_t              regs;
	outcome_t          pending_results [$];
	bit                end_checked;

	function automatic int slot_of(input logic [CARD_W-1:0] value);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (cards[i] == value)
				return i;
		return -1;
	endfunction

	// supervisor numbers take priority in a fixed order, then table lookup
	function automatic card_class_t classify_card(input logic [CARD_W-1:0] card);
		if (card == regs.add_sup_id)
			return CLS_SUP_ADD;
		if (card == regs.erase_sup_id)
			return CLS_SUP_ERASE;
		if (card == regs.erase_all_sup_id)
			return CLS_SUP_ERASE_ALL;
		if (card != EMPTY_SLOT && slot_of(card) >= 0)
			return CLS_KNOWN;
		return CLS_UNKNOWN;
	endfunction

	function automatic void reset_model();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			cards[i] = EMPTY_SLOT;
		cur_mode              = MODE_IDLE;
		ticks_left            = '0;
		regs.add_sup_id       = RST_ADD_SUP;
		regs.erase_sup_id     = RST_ERASE_SUP;
		regs.erase_all_sup_id = RST_ERASE_ALL_SUP;
		regs.open_ticks       = RST_OPEN_TICKS;
		regs.wait_ticks       = RST_WAIT_TICKS;
	endfunction

	// advance the controller by one event and return its result
	function automatic outcome_t step_controller(input logic cmd,
			input logic [CARD_W-1:0] card);
		outcome_t    o;
		card_class_t cls;
		int          slot;
		o = '0;
		o.status = STAT_NONE;
		if (cmd == CMD_TICK) begin
			if (cur_mode != MODE_IDLE) begin
				if (ticks_left <= 1) begin
					ticks_left = '0;
					o.status   = (cur_mode == MODE_OPEN) ? STAT_CLOSED : STAT_TIMEOUT;
					cur_mode   = MODE_IDLE;
				end else begin
					ticks_left = ticks_left - 1'b1;
				end
			end
		end else begin
			cls = classify_card(card);
			case (cur_mode)
				MODE_IDLE: begin
					if (cls == CLS_KNOWN) begin
						cur_mode   = MODE_OPEN;
						ticks_left = regs.open_ticks;
						o.status   = STAT_OPENED;
					end else if (cls == CLS_SUP_ERASE_ALL) begin
						for (int i = 0; i < TABLE_ENTRIES; i++)
							cards[i] = EMPTY_SLOT;
						o.status   = STAT_ALL_ERASED;
						o.ok_flash = 1'b1;
					end else if (cls == CLS_SUP_ERASE) begin
						cur_mode   = MODE_ERASE;
						ticks_left = regs.wait_ticks;
					end else if (cls == CLS_SUP_ADD) begin
						cur_mode   = MODE_ADD;
						ticks_left = regs.wait_ticks;
					end else begin
						o.status = STAT_REJECTED;
					end
				end
				MODE_OPEN: begin
					cur_mode = MODE_IDLE;
					o.status = STAT_CLOSED;
				end
				MODE_ERASE: begin
					cur_mode = MODE_IDLE;
					if (cls == CLS_KNOWN) begin
						slot = slot_of(card);
						if (slot >= 0)
							cards[slot] = EMPTY_SLOT;
						o.status   = STAT_ERASED;
						o.ok_flash = 1'b1;
					end else begin
						o.status = STAT_NOT_FOUND;
					end
				end
				default: begin
					cur_mode = MODE_IDLE;
					if (cls == CLS_UNKNOWN) begin
						// card zero would look like an empty slot
						if (card == EMPTY_SLOT) begin
							o.status = STAT_REJECTED;
						end else begin
							slot = slot_of(EMPTY_SLOT);
							if (slot >= 0) begin
								cards[slot] = card;
								o.status    = STAT_ADDED;
							end else begin
								o.status = STAT_FULL;
							end
							o.ok_flash = 1'b1;
						end
					end else if (cls == CLS_KNOWN) begin
						o.status = STAT_PRESENT;
					end else begin
						o.status = STAT_REJECTED;
					end
				end
			endcase
		end
		o.mode       = cur_mode;
		o.door_open  = (cur_mode == MODE_OPEN);
		o.busy_blink = (cur_mode == MODE_ERASE || cur_mode == MODE_ADD);
		return o;
	endfunction

	task automatic check_field(input string field, input logic [3:0] want,
			input logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// model update, comparison and end-of-run check
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			reset_model();
			pending_results.delete();
			mismatches  = 0;
			end_checked = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ADD_SUP:       regs.add_sup_id       = cfg_data;
					REG_ERASE_SUP:     regs.erase_sup_id     = cfg_data;
					REG_ERASE_ALL_SUP: regs.erase_all_sup_id = cfg_data;
					REG_OPEN_TICKS:    regs.open_ticks       = cfg_data;
					REG_WAIT_TICKS:    regs.wait_ticks       = cfg_data;
					default: ;
				endcase
			end
			// result first: it can never belong to an event taken this edge
			if (res.valid && res.ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no event waiting (status %0d)", res.status);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("mode", want.mode, res.mode);
					check_field("door_open", want.door_open, res.door_open);
					check_field("busy_blink", want.busy_blink, res.busy_blink);
					check_field("ok_flash", want.ok_flash, res.ok_flash);
					check_field("status", want.status, res.status);
				end
			end
			if (ev.valid && ev.ready)
				pending_results.push_back(step_controller(ev.command, ev.card_number));
			if (run_done && !end_checked) begin
				end_checked = 1'b1;
				if (pending_results.size() != 0) begin
					$error("%0d results never arrived", pending_results.size());
					mismatches++;
				end
			end
		end
	end

endmodule

@@ tb/tb_card_access_controller.sv @@
// ----------------------------------------------------------------------------
// tb_card_access_controller
// Drives card reads and ticks into the controller under several register
// settings: a short directed list, then mixed add / erase / open sequences
// with random content, a table fill and random noise. Both channel sides
// idle at random; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_card_access_controller;
	import cac_pkg::*;

	localparam int TABLE_ENTRIES = 32;
	localparam int RUN_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES + 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int POOL_SIZE     = 48;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 run_done;
	int                   mismatches;

	int n_sent, n_results, n_cards, n_ticks, n_settings;
	int src_idle_pct, sink_idle_pct;
	bit hold_req;

	// register values currently loaded, used to build sequences
	logic [CFG_W-1:0]  sup_add, sup_erase, sup_all, cur_open, cur_wait;
	logic [CARD_W-1:0] pool [POOL_SIZE];

	cac_event_if  event_ch();
	cac_result_if result_ch();

	card_access_controller #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.event_ch  (event_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cac_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (event_ch),
		.res        (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.run_done   (run_done),
		.mismatches (mismatches)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycle limit
	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$error("cycle limit reached with %0d of %0d results", n_results, n_sent);
		$display("Regression FAIL");
		$finish;
	end

	// result side: random ready, one long hold-off on request
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				n_results++;
			if (hold_req && arst_n) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic send_event(input logic cmd, input logic [CARD_W-1:0] card);
		while ($urandom_range(99) < src_idle_pct) begin
			event_ch.valid <= 1'b0;
			@(posedge clk);
		end
		event_ch.valid       <= 1'b1;
		event_ch.command     <= cmd;
		event_ch.card_number <= card;
		@(posedge clk);
		while (!event_ch.ready) @(posedge clk);
		n_sent++;
		if (cmd == CMD_TICK)
			n_ticks++;
		else
			n_cards++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_event(CMD_TICK, CARD_W'($urandom));
	endtask

	// stop offering, wait for every result, then let the block settle
	task automatic wait_quiet();
		event_ch.valid <= 1'b0;
		@(posedge clk);
		while (n_results != n_sent) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_W-1:0] add_id, erase_id, all_id, open_n,
			wait_n);
		write_reg(REG_ADD_SUP, add_id);
		write_reg(REG_ERASE_SUP, erase_id);
		write_reg(REG_ERASE_ALL_SUP, all_id);
		write_reg(REG_OPEN_TICKS, open_n);
		write_reg(REG_WAIT_TICKS, wait_n);
		cfg_we    <= 1'b0;
		sup_add   = add_id;
		sup_erase = erase_id;
		sup_all   = all_id;
		cur_open  = open_n;
		cur_wait  = wait_n;
		n_settings++;
	endtask

	task automatic refill_pool();
		foreach (pool[i])
			pool[i] = CARD_W'($urandom_range(65535, 1));
	endtask

	// mostly short tick runs; with a short timer, sometimes past its end
	function automatic int tick_run(input logic [CFG_W-1:0] span);
		if (span <= 6 && $urandom_range(1) == 1)
			return $urandom_range(span + 1);
		return $urandom_range(2);
	endfunction

	function automatic logic [CARD_W-1:0] pick_card();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return pool[$urandom_range(POOL_SIZE - 1)];
		if (r < 53)
			return EMPTY_SLOT;
		if (r < 58)
			return sup_add;
		if (r < 63)
			return sup_erase;
		if (r < 68)
			return sup_all;
		return CARD_W'($urandom);
	endfunction

	// one of each decision but a full table, with open 2 and wait 3
	task automatic run_directed();
		logic [CARD_W-1:0] known;
		known = 16'hFFFF;
		send_event(CMD_TICK, 16'h0000);
		send_event(CMD_CARD, EMPTY_SLOT);
		send_event(CMD_CARD, sup_add);
		send_event(CMD_CARD, known);
		send_event(CMD_CARD, sup_add);
		send_event(CMD_CARD, EMPTY_SLOT);
		send_event(CMD_CARD, sup_add);
		send_event(CMD_CARD, known);
		send_event(CMD_CARD, sup_add);
		send_event(CMD_CARD, sup_erase);
		// door open, then closed by timeout and by another card
		send_event(CMD_CARD, known);
		send_ticks(2);
		send_event(CMD_CARD, known);
		send_event(CMD_CARD, 16'h0001);
		// armed erase runs out
		send_event(CMD_CARD, sup_erase);
		send_ticks(3);
		send_event(CMD_CARD, sup_erase);
		send_event(CMD_CARD, EMPTY_SLOT);
		send_event(CMD_CARD, sup_erase);
		send_event(CMD_CARD, known);
		send_event(CMD_CARD, sup_erase);
		send_event(CMD_CARD, sup_all);
		send_event(CMD_CARD, sup_all);
	endtask

	// send the erase-all card, then add more fresh cards than the table holds
	task automatic fill_table();
		send_event(CMD_CARD, sup_all);
		repeat (TABLE_ENTRIES + 4) begin
			send_event(CMD_CARD, sup_add);
			send_event(CMD_CARD, CARD_W'($urandom_range(65535, 1)));
		end
	endtask

	task automatic run_random(input int count);
		int stop_at;
		int pick;
		stop_at = n_sent + count;
		while (n_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 28) begin
				send_event(CMD_CARD, sup_add);
				send_ticks(tick_run(cur_wait));
				send_event(CMD_CARD, ($urandom_range(1) == 1) ?
					CARD_W'($urandom) : pick_card());
			end else if (pick < 43) begin
				send_event(CMD_CARD, sup_erase);
				send_ticks(tick_run(cur_wait));
				send_event(CMD_CARD, pick_card());
			end else if (pick < 70) begin
				send_event(CMD_CARD, pool[$urandom_range(POOL_SIZE - 1)]);
				send_ticks(tick_run(cur_open));
			end else if (pick < 73) begin
				send_event(CMD_CARD, sup_all);
			end else if ($urandom_range(1) == 1) begin
				send_event(CMD_TICK, CARD_W'($urandom));
			end else begin
				send_event(CMD_CARD, CARD_W'($urandom));
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		logic [CFG_W-1:0] dup_id;
		event_ch.valid       <= 1'b0;
		event_ch.command     <= CMD_TICK;
		event_ch.card_number <= '0;
		cfg_we               <= 1'b0;
		cfg_index            <= '0;
		cfg_data             <= '0;
		run_done             <= 1'b0;
		hold_req      = 1'b0;
		src_idle_pct  = 33;
		sink_idle_pct = 70;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(16'h1234, 16'h8421, 16'h0FF0, 16'd2, 16'd3);
		run_directed();
		wait_quiet();

		// short random timers; long result stall, then a full drain
		set_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom_range(5, 1)), CFG_W'($urandom_range(5, 1)));
		refill_pool();
		hold_req = 1'b1;
		run_random(150);
		wait_quiet();
		run_random(150);
		wait_quiet();

		// extreme supervisor numbers and the shortest timers
		src_idle_pct  = 70;
		sink_idle_pct = 33;
		set_config(16'h0000, 16'hFFFF, 16'h8000, 16'd1, 16'd1);
		refill_pool();
		run_random(280);
		wait_quiet();

		// shared supervisor number, longest timers, table overflow
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		dup_id = CFG_W'($urandom_range(65535, 1));
		set_config(CFG_W'($urandom), dup_id, dup_id, 16'hFFFF, 16'hFFFF);
		refill_pool();
		fill_table();
		run_random(100);
		wait_quiet();

		set_config(RST_ADD_SUP, RST_ERASE_SUP, RST_ERASE_ALL_SUP, 16'd3, 16'd2);
		refill_pool();
		run_random(220);
		wait_quiet();

		run_done <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Covered %0d card reads and %0d ticks over %0d register settings;",
			n_cards, n_ticks, n_settings);
		$display("%0d results checked, %0d mismatches.", n_results, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
